// ===== rtl/core/pcmr_pkg.sv =====
`timescale 1ns / 1ps

package pcmr_pkg;

	localparam int MAX_CH   = 8;
	localparam int SAMPLE_W = 16;
	localparam int CNT_W    = $clog2(MAX_CH + 1);
	localparam int IDX_W    = $clog2(MAX_CH);
	localparam int NPAIR    = MAX_CH / 2;
	localparam int PAIR_W   = SAMPLE_W + 1;
	localparam int SUM_W    = SAMPLE_W + $clog2(MAX_CH);
	localparam int RECIP_SH = SUM_W + 3;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam int REM_W    = CNT_W + 1;
	localparam int DATA_W   = 4;

	// register indexes
	localparam logic REG_IN_CH  = 1'b0;
	localparam logic REG_OUT_CH = 1'b1;

	// output channel selector codes
	localparam logic [1:0] SEL_SAME   = 2'd0;
	localparam logic [1:0] SEL_MONO   = 2'd1;
	localparam logic [1:0] SEL_STEREO = 2'd2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_MONO,
		MODE_DUP,
		MODE_TOP2
	} mode_t;

	typedef struct packed {
		mode_t            mode;
		logic [CNT_W-1:0] nin;
	} ctl_t;

	// floor(2^RECIP_SH / n), so the scaled quotient is at most one short
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			CNT_W'(2): r = RECIP_W'((64'd1 << RECIP_SH) / 2);
			CNT_W'(3): r = RECIP_W'((64'd1 << RECIP_SH) / 3);
			CNT_W'(4): r = RECIP_W'((64'd1 << RECIP_SH) / 4);
			CNT_W'(5): r = RECIP_W'((64'd1 << RECIP_SH) / 5);
			CNT_W'(6): r = RECIP_W'((64'd1 << RECIP_SH) / 6);
			CNT_W'(7): r = RECIP_W'((64'd1 << RECIP_SH) / 7);
			CNT_W'(8): r = RECIP_W'((64'd1 << RECIP_SH) / 8);
			default:   r = RECIP_W'(64'd1 << RECIP_SH);
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/pcm_channel_remixer.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// input     in         in_valid/in_stall   chan0 .. chan7, one frame per word
// output    out        out_valid/out_stall out_sample, frame_last
// config    in         wr_en               wr_index, wr_data
//
// a frame may enter every cycle while in_stall is low, and passes six pipeline
// stages on its way to the output; each frame leaves as 1, 2 or input_channels
// words, one per cycle while out_stall is low; the output serialiser sets the rate
// reset: 2 input channels, output same as input, pipeline and serialiser empty
// out_stall freezes the serialiser; the pipeline then stalls once stage six holds
// a frame, and in_stall is raised

module pcm_channel_remixer import pcmr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  sample_t           chan0,
	input  sample_t           chan1,
	input  sample_t           chan2,
	input  sample_t           chan3,
	input  sample_t           chan4,
	input  sample_t           chan5,
	input  sample_t           chan6,
	input  sample_t           chan7,
	output logic              out_valid,
	input  logic              out_stall,
	output sample_t           out_sample,
	output logic              frame_last
);

	logic [3:0] in_ch_q;
	logic [1:0] out_ch_q;

	ctl_t                 ctl_in;
	logic [CNT_W-1:0]     nin;
	logic [CNT_W-1:0]     nout;
	sample_t [MAX_CH-1:0] chan_in;

	logic                 v_s6;
	ctl_t                 ctl_s6;
	sample_t [MAX_CH-1:0] chan_s6;
	sample_t              mean_s6;
	logic                 ser_free;
	logic                 adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q  <= 4'd2;
			out_ch_q <= SEL_SAME;
		end else if (wr_en) begin
			case (wr_index)
				REG_IN_CH:  in_ch_q  <= wr_data[3:0];
				REG_OUT_CH: out_ch_q <= wr_data[1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		if (in_ch_q == 4'd0)
			nin = CNT_W'(1);
		else if ({1'b0, in_ch_q} > 5'(MAX_CH))
			nin = CNT_W'(MAX_CH);
		else
			nin = CNT_W'(in_ch_q);

		case (out_ch_q)
			SEL_MONO:   nout = CNT_W'(1);
			SEL_STEREO: nout = CNT_W'(2);
			default:    nout = nin;
		endcase

		ctl_in.nin = nin;
		if (nout == nin)
			ctl_in.mode = MODE_PASS;
		else if (nout == CNT_W'(1))
			ctl_in.mode = MODE_MONO;
		else if (nin == CNT_W'(1))
			ctl_in.mode = MODE_DUP;
		else
			ctl_in.mode = MODE_TOP2;
	end

	assign chan_in = {chan7, chan6, chan5, chan4, chan3, chan2, chan1, chan0};

	assign adv      = !v_s6 || ser_free;
	assign in_stall = !adv;

	pcmr_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (in_valid),
		.ctl_in   (ctl_in),
		.chan_in  (chan_in),
		.v_out    (v_s6),
		.ctl_out  (ctl_s6),
		.chan_out (chan_s6),
		.mean_out (mean_s6)
	);

	pcmr_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (v_s6),
		.ctl        (ctl_s6),
		.chan       (chan_s6),
		.mean       (mean_s6),
		.stall      (out_stall),
		.free       (ser_free),
		.valid      (out_valid),
		.out_sample (out_sample),
		.frame_last (frame_last)
	);

endmodule

// ===== rtl/core/pcmr_datapath.sv =====
`timescale 1ns / 1ps

module pcmr_datapath import pcmr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  ctl_t                     ctl_in,
	input  sample_t [MAX_CH-1:0]     chan_in,
	output logic                     v_out,
	output ctl_t                     ctl_out,
	output sample_t [MAX_CH-1:0]     chan_out,
	output sample_t                  mean_out
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	sample_t [MAX_CH-1:0] chan_s1, chan_s2, chan_s3, chan_s4, chan_s5, chan_s6;

	logic [MAX_CH-1:0][SAMPLE_W-1:0] bias;
	logic [NPAIR-1:0][PAIR_W-1:0]    pair_s2;
	logic [SUM_W-1:0]                sum_c, sum_s3, sum_s4;
	logic [RECIP_W-1:0]              recip_s3;
	logic [PROD_W-1:0]               prod_s4;
	logic [SUM_W-1:0]                q0;
	logic [SUM_W+CNT_W-1:0]          qn;
	logic [SUM_W-1:0]                diff;
	logic [SUM_W-1:0]                q_s5;
	logic [REM_W-1:0]                rem_s5;
	logic [SUM_W-1:0]                qc, qf;
	logic [CNT_W-1:0]                rc;
	logic [REM_W-1:0]                twice;
	logic                            round_up;
	sample_t                         mean_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// offset binary, unused channels count as zero
	always_comb begin
		for (int k = 0; k < MAX_CH; k++) begin
			if (CNT_W'(k) < ctl_s1.nin)
				bias[k] = {~chan_s1[k][SAMPLE_W-1], chan_s1[k][SAMPLE_W-2:0]};
			else
				bias[k] = '0;
		end
	end

	always_comb begin
		sum_c = '0;
		for (int j = 0; j < NPAIR; j++)
			sum_c = sum_c + SUM_W'(pair_s2[j]);
	end

	// quotient estimate and its remainder, at most one divisor too large
	assign q0   = prod_s4[RECIP_SH+SUM_W-1:RECIP_SH];
	assign qn   = q0 * ctl_s4.nin;
	assign diff = sum_s4 - qn[SUM_W-1:0];

	always_comb begin
		if (rem_s5 >= REM_W'(ctl_s5.nin)) begin
			qc = q_s5 + SUM_W'(1);
			rc = CNT_W'(rem_s5 - REM_W'(ctl_s5.nin));
		end else begin
			qc = q_s5;
			rc = rem_s5[CNT_W-1:0];
		end
		twice    = {rc, 1'b0};
		// ties go to the even quotient
		round_up = (twice > REM_W'(ctl_s5.nin)) ||
		           ((twice == REM_W'(ctl_s5.nin)) && qc[0]);
		qf       = qc + SUM_W'(round_up);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1   <= ctl_in;
			chan_s1  <= chan_in;

			ctl_s2   <= ctl_s1;
			chan_s2  <= chan_s1;
			for (int j = 0; j < NPAIR; j++)
				pair_s2[j] <= {1'b0, bias[2*j]} + {1'b0, bias[2*j+1]};

			ctl_s3   <= ctl_s2;
			chan_s3  <= chan_s2;
			sum_s3   <= sum_c;
			recip_s3 <= recip(ctl_s2.nin);

			ctl_s4   <= ctl_s3;
			chan_s4  <= chan_s3;
			sum_s4   <= sum_s3;
			prod_s4  <= PROD_W'(sum_s3) * PROD_W'(recip_s3);

			ctl_s5   <= ctl_s4;
			chan_s5  <= chan_s4;
			q_s5     <= q0;
			rem_s5   <= diff[REM_W-1:0];

			ctl_s6   <= ctl_s5;
			chan_s6  <= chan_s5;
			mean_s6  <= {~qf[SAMPLE_W-1], qf[SAMPLE_W-2:0]};
		end
	end

	assign v_out    = v_s6;
	assign ctl_out  = ctl_s6;
	assign chan_out = chan_s6;
	assign mean_out = mean_s6;

endmodule

// ===== rtl/core/pcmr_serial.sv =====
`timescale 1ns / 1ps

module pcmr_serial import pcmr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_valid,
	input  ctl_t                 ctl,
	input  sample_t [MAX_CH-1:0] chan,
	input  sample_t              mean,
	input  logic                 stall,
	output logic                 free,
	output logic                 valid,
	output sample_t              out_sample,
	output logic                 frame_last
);

	logic                 busy_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     cnt_q;
	sample_t [MAX_CH-1:0] res_q;

	sample_t [MAX_CH-1:0] res;
	logic [CNT_W-1:0]     cnt;
	logic                 last, take, done, load;

	always_comb begin
		res = chan;
		case (ctl.mode)
			MODE_PASS: cnt = ctl.nin;
			MODE_MONO: begin
				cnt    = CNT_W'(1);
				res[0] = mean;
			end
			MODE_DUP: begin
				cnt    = CNT_W'(2);
				res[1] = chan[0];
			end
			default:   cnt = CNT_W'(2);
		endcase
	end

	assign last = ({1'b0, idx_q} + CNT_W'(1)) == cnt_q;
	assign take = busy_q && !stall;
	assign done = take && last;
	assign free = !busy_q || done;
	assign load = load_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			cnt_q  <= cnt;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (take) begin
			idx_q  <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

	assign valid      = busy_q;
	assign out_sample = res_q[idx_q];
	assign frame_last = last;

endmodule
